FILE: rtl/rational_arith_reduce_core_assert.svh
// assertion macros used by the port-level checker
`ifndef RATIONAL_ARITH_REDUCE_CORE_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RAR_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define RAR_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

FILE: rtl/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types and constants of the rational arithmetic reduce core.
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int unsigned OPERAND_WIDTH_DEF = 16;
  localparam int unsigned FIELD_W           = 16;
  localparam int unsigned NUM_W             = 33;
  localparam int unsigned DEN_W             = 31;
  localparam int unsigned QUEUE_DEPTH       = 2;

  // operation codes
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_DIV    = 2'd1;
  localparam logic [1:0] FUNC_MUL    = 2'd2;
  localparam logic [1:0] FUNC_BAD_OP = 2'd3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_BAD_OP   = 2'd2,
    ST_ZERO_DEN = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [FIELD_W-1:0] lhs_numerator;
    logic signed [FIELD_W-1:0] lhs_denominator;
    logic signed [FIELD_W-1:0] rhs_numerator;
    logic signed [FIELD_W-1:0] rhs_denominator;
  } in_beat_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] result_numerator;
    logic [DEN_W-1:0]        result_denominator;
    logic [1:0]              status;
  } out_beat_t;

  // control part of a queued job
  typedef struct packed {
    logic    reduce;
    logic    neg;
    status_e status;
  } job_ctl_t;

  localparam int unsigned JOB_CTL_W = $bits(job_ctl_t);

endpackage

FILE: rtl/rar_fifo.sv
// ----------------------------------------------------------------------------
// rar_fifo
// Small register queue between the front and the back part.
// ----------------------------------------------------------------------------
module rar_fifo
  import rar_pkg::*;
#(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] store_q [DEPTH];
  logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [AW:0]       count_q;

  assign full_o     = (count_q == (AW+1)'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = store_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/rar_front.sv
// ----------------------------------------------------------------------------
// rar_front
// Takes input beats, forms the cross products and classifies the job.
// ----------------------------------------------------------------------------
module rar_front
  import rar_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF,
  parameter int unsigned GW            = 2 * OPERAND_WIDTH + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  in_beat_t      in_data_i,
  input  logic          queue_full_i,
  output logic          push_o,
  output job_ctl_t      ctl_o,
  output logic [GW-1:0] nmag_o,
  output logic [GW-1:0] dmag_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned PW = 2 * W;

  typedef struct packed {
    logic         neg;
    logic [W-1:0] mag;
  } smag_t;

  function automatic smag_t to_smag(input logic [FIELD_W-1:0] raw);
    logic [W-1:0] v;
    smag_t        r;
    v     = W'(raw);
    r.neg = v[W-1];
    r.mag = v[W-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  smag_t ln, ld, rn, rd;

  logic          s1_valid_q;
  logic [1:0]    func_q;
  logic          ln_neg_q, ld_neg_q, rn_neg_q, rd_neg_q;
  logic          rn_zero_q;
  logic [PW-1:0] p_lnrd_q, p_rnld_q, p_ldrd_q, p_lnrn_q;
  logic          accept;

  assign ln = to_smag(in_data_i.lhs_numerator);
  assign ld = to_smag(in_data_i.lhs_denominator);
  assign rn = to_smag(in_data_i.rhs_numerator);
  assign rd = to_smag(in_data_i.rhs_denominator);

  assign in_stall_o = s1_valid_q & queue_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = s1_valid_q & ~queue_full_i;

  // product stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept | (s1_valid_q & queue_full_i);
    end
  end

  // product stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= in_data_i.func;
      ln_neg_q  <= ln.neg;
      ld_neg_q  <= ld.neg;
      rn_neg_q  <= rn.neg;
      rd_neg_q  <= rd.neg;
      rn_zero_q <= (rn.mag == '0);
      p_lnrd_q  <= PW'(ln.mag) * PW'(rd.mag);
      p_rnld_q  <= PW'(rn.mag) * PW'(ld.mag);
      p_ldrd_q  <= PW'(ld.mag) * PW'(rd.mag);
      p_lnrn_q  <= PW'(ln.mag) * PW'(rn.mag);
    end
  end

  logic          sa, sb, sum_neg, n_neg, d_neg;
  logic [GW-1:0] pa, pb, sum_mag, n_mag, d_mag;

  // signed add of the two cross products
  always_comb begin
    sa = (ln_neg_q ^ rd_neg_q) & (p_lnrd_q != '0);
    sb = (rn_neg_q ^ ld_neg_q) & (p_rnld_q != '0);
    pa = GW'(p_lnrd_q);
    pb = GW'(p_rnld_q);
    if (sa == sb) begin
      sum_mag = pa + pb;
      sum_neg = sa;
    end else if (pa >= pb) begin
      sum_mag = pa - pb;
      sum_neg = sa;
    end else begin
      sum_mag = pb - pa;
      sum_neg = sb;
    end
  end

  // operation select and classification
  always_comb begin
    n_mag = '0;
    d_mag = GW'(1);
    n_neg = 1'b0;
    d_neg = 1'b0;
    ctl_o = '{reduce: 1'b0, neg: 1'b0, status: ST_OK};
    case (func_q)
      FUNC_ADD: begin
        n_mag = sum_mag;
        n_neg = sum_neg;
        d_mag = GW'(p_ldrd_q);
        d_neg = ld_neg_q ^ rd_neg_q;
      end
      FUNC_DIV: begin
        n_mag = GW'(p_lnrd_q);
        n_neg = ln_neg_q ^ rd_neg_q;
        d_mag = GW'(p_rnld_q);
        d_neg = rn_neg_q ^ ld_neg_q;
      end
      FUNC_MUL: begin
        n_mag = GW'(p_lnrn_q);
        n_neg = ln_neg_q ^ rn_neg_q;
        d_mag = GW'(p_ldrd_q);
        d_neg = ld_neg_q ^ rd_neg_q;
      end
      default: begin
        ctl_o.status = ST_BAD_OP;
      end
    endcase
    nmag_o = '0;
    dmag_o = GW'(1);
    if (ctl_o.status == ST_BAD_OP) begin
      ctl_o.reduce = 1'b0;
    end else if (func_q == FUNC_DIV && rn_zero_q) begin
      ctl_o.status = ST_DIV_ZERO;
    end else if (d_mag == '0) begin
      ctl_o.status = ST_ZERO_DEN;
    end else if (n_mag != '0) begin
      ctl_o.reduce = 1'b1;
      ctl_o.neg    = n_neg ^ d_neg;
      nmag_o       = n_mag;
      dmag_o       = d_mag;
    end
  end

endmodule

FILE: rtl/rar_back.sv
// ----------------------------------------------------------------------------
// rar_back
// Binary GCD and two shift-subtract divisions (reducible jobs), output register.
// ----------------------------------------------------------------------------
module rar_back
  import rar_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF,
  parameter int unsigned GW            = 2 * OPERAND_WIDTH + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  output logic          pop_o,
  input  job_ctl_t      ctl_i,
  input  logic [GW-1:0] nmag_i,
  input  logic [GW-1:0] dmag_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output out_beat_t     out_data_o
);

  localparam int unsigned KW = $clog2(GW + 1);
  localparam int unsigned CW = $clog2(GW);
  localparam int unsigned OW = (GW > NUM_W) ? GW : NUM_W;
  localparam int unsigned DW = (GW > DEN_W) ? GW : DEN_W;

  typedef enum logic [4:0] {
    BK_IDLE = 5'b00001,
    BK_GCD  = 5'b00010,
    BK_DIVN = 5'b00100,
    BK_DIVD = 5'b01000,
    BK_DONE = 5'b10000
  } back_state_e;

  back_state_e   state_q, state_d;
  logic          out_valid_q, out_valid_d;
  out_beat_t     out_data_q;
  logic [CW-1:0] cnt_q;
  logic [KW-1:0] k_q;
  logic [GW-1:0] n_q, d_q, a_q, b_q, g_q, rem_q, q_q, nq_q;
  logic          neg_q;
  status_e       status_q;

  logic            last_step, emit;
  logic [GW:0]     trial, diff;
  logic            ge;
  logic [GW-1:0]   rem_nx, q_nx;
  logic [OW-1:0]   num_ext;
  logic [DW-1:0]   den_ext;

  assign pop_o       = (state_q == BK_IDLE) & ~empty_i;
  assign last_step   = (cnt_q == CW'(GW - 1));
  assign emit        = (state_q == BK_DONE) & (~out_valid_q | ~out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // one shift-subtract division step
  always_comb begin
    trial  = {rem_q, q_q[GW-1]};
    diff   = trial - {1'b0, g_q};
    ge     = (trial >= {1'b0, g_q});
    rem_nx = ge ? diff[GW-1:0] : trial[GW-1:0];
    q_nx   = {q_q[GW-2:0], ge};
  end

  // result formatting
  always_comb begin
    num_ext = OW'(nq_q);
    if (neg_q) begin
      num_ext = ~num_ext + 1'b1;
    end
    den_ext = DW'(q_q);
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & out_stall_i;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          state_d = ctl_i.reduce ? BK_GCD : BK_DONE;
        end
      end
      BK_GCD: begin
        if (a_q == b_q) begin
          state_d = BK_DIVN;
        end
      end
      BK_DIVN: begin
        if (last_step) begin
          state_d = BK_DIVD;
        end
      end
      BK_DIVD: begin
        if (last_step) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (emit) begin
          state_d     = BK_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        n_q      <= nmag_i;
        d_q      <= dmag_i;
        a_q      <= nmag_i;
        b_q      <= dmag_i;
        nq_q     <= nmag_i;
        q_q      <= dmag_i;
        k_q      <= '0;
        neg_q    <= ctl_i.neg;
        status_q <= ctl_i.status;
      end
      BK_GCD: begin
        if (a_q == b_q) begin
          g_q   <= a_q << k_q;
          q_q   <= n_q;
          rem_q <= '0;
          cnt_q <= '0;
        end else if (!a_q[0] && !b_q[0]) begin
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!a_q[0]) begin
          a_q <= a_q >> 1;
        end else if (!b_q[0]) begin
          b_q <= b_q >> 1;
        end else if (a_q > b_q) begin
          a_q <= (a_q - b_q) >> 1;
        end else begin
          b_q <= (b_q - a_q) >> 1;
        end
      end
      BK_DIVN: begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          nq_q  <= q_nx;
          q_q   <= d_q;
          rem_q <= '0;
          cnt_q <= '0;
        end else begin
          q_q   <= q_nx;
          rem_q <= rem_nx;
        end
      end
      BK_DIVD: begin
        cnt_q <= cnt_q + 1'b1;
        q_q   <= q_nx;
        rem_q <= rem_nx;
      end
      default: begin
        if (emit) begin
          out_data_q.result_numerator   <= num_ext[NUM_W-1:0];
          out_data_q.result_denominator <= den_ext[DEN_W-1:0];
          out_data_q.status             <= status_q;
        end
      end
    endcase
  end

endmodule

FILE: rtl/rational_arith_reduce_core.sv
// ----------------------------------------------------------------------------
// rational_arith_reduce_core
// Adds, divides or multiplies two signed fractions and reduces the result.
// ----------------------------------------------------------------------------
// One result beat per input beat, in order. The front registers the four
// cross products, classifies the job from them and queues it; the back
// reduces it with a binary GCD (one shift or subtract a cycle) and then
// divides numerator and denominator by the GCD on one shared shift-subtract
// unit. The back takes the next job from the queue only when idle, so its
// single division unit sets the sustained rate.
module rational_arith_reduce_core
  import rar_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int unsigned GW   = 2 * OPERAND_WIDTH + 1;
  localparam int unsigned QD_W = JOB_CTL_W + 2 * GW;

  logic          push, pop, full, empty;
  job_ctl_t      f_ctl, b_ctl;
  logic [GW-1:0] f_nmag, f_dmag, b_nmag, b_dmag;
  logic [QD_W-1:0] q_out;

  // classification front
  rar_front #(
    .OPERAND_WIDTH(OPERAND_WIDTH),
    .GW           (GW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .queue_full_i(full),
    .push_o      (push),
    .ctl_o       (f_ctl),
    .nmag_o      (f_nmag),
    .dmag_o      (f_dmag)
  );

  // job queue
  rar_fifo #(
    .DATA_W(QD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({f_ctl, f_nmag, f_dmag}),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (q_out),
    .empty_o    (empty)
  );

  assign {b_ctl, b_nmag, b_dmag} = q_out;

  // reduction back end
  rar_back #(
    .OPERAND_WIDTH(OPERAND_WIDTH),
    .GW           (GW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_o      (pop),
    .ctl_i      (b_ctl),
    .nmag_i     (b_nmag),
    .dmag_i     (b_dmag),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: rtl/rar_checker.sv
// ----------------------------------------------------------------------------
// rar_checker
// Port-level checks on the input and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "rational_arith_reduce_core_assert.svh"

module rar_checker
  import rar_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_beat_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);

  logic err_beat, zero_num, unit_den;

  assign err_beat = out_valid_o && (out_data_o.status != ST_OK);
  assign zero_num = (out_data_o.result_numerator == '0);
  assign unit_den = (out_data_o.result_denominator == DEN_W'(1));

  // a stalled input beat stays valid and unchanged
  `RAR_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable(in_data_i))
  // a stalled result beat stays valid
  `RAR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  // error beats carry 0/1
  `RAR_ASSERT_IMP(a_err_zero, clk_i, rst_ni, err_beat, zero_num && unit_den)
  // a good result never has a zero denominator
  `RAR_ASSERT_IMP(a_den_nz, clk_i, rst_ni, out_valid_o && (out_data_o.status == ST_OK), out_data_o.result_denominator != '0)
  // a zero result is always 0/1
  `RAR_ASSERT_IMP(a_zero_unit, clk_i, rst_ni, out_valid_o && zero_num, unit_den)

endmodule

bind rational_arith_reduce_core rar_checker u_rar_checker (.*);

FILE: sim/rational_arith_reduce_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arith_reduce_checker
// Watches both channels of the core, predicts each reduced fraction from the
// accepted input beat and compares it with the next result beat.
// ----------------------------------------------------------------------------
module rational_arith_reduce_checker
  import rar_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_beat_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_beat_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  out_beat_t fraction_q[$];
  int        fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = fraction_q.size();

  // print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // exact signed arithmetic on 64-bit integers, then reduce
  function automatic out_beat_t reduce_fraction(in_beat_t b);
    out_beat_t       r;
    longint          ln, ld, rn, rd, num, den;
    longint unsigned nm, dm, g;
    ln = b.lhs_numerator;
    ld = b.lhs_denominator;
    rn = b.rhs_numerator;
    rd = b.rhs_denominator;
    r.result_numerator   = '0;
    r.result_denominator = DEN_W'(1);
    r.status             = ST_OK;
    case (b.func)
      FUNC_ADD: begin
        num = ln * rd + rn * ld;
        den = ld * rd;
      end
      FUNC_DIV: begin
        if (rn == 0) begin
          r.status = ST_DIV_ZERO;
          return r;
        end
        num = ln * rd;
        den = rn * ld;
      end
      FUNC_MUL: begin
        num = ln * rn;
        den = ld * rd;
      end
      default: begin
        r.status = ST_BAD_OP;
        return r;
      end
    endcase
    if (den == 0) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    if (num == 0) return r;
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    g  = gcd_of(nm, dm);
    nm = nm / g;
    dm = dm / g;
    r.result_numerator   = NUM_W'(((num < 0) != (den < 0)) ? -nm : nm);
    r.result_denominator = DEN_W'(dm);
    return r;
  endfunction

  // collect expectations and compare results
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      fail_count = 0;
      fraction_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) fraction_q.push_back(reduce_fraction(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (fraction_q.size() == 0) begin
          report_mismatch("unexpected beat", 64'(out_data_i.result_numerator), 64'd0);
        end else begin
          want = fraction_q.pop_front();
          if (out_data_i.result_numerator !== want.result_numerator)
            report_mismatch("numerator", 64'(out_data_i.result_numerator),
                            64'(want.result_numerator));
          if (out_data_i.result_denominator !== want.result_denominator)
            report_mismatch("denominator", 64'(out_data_i.result_denominator),
                            64'(want.result_denominator));
          if (out_data_i.status !== want.status)
            report_mismatch("status", 64'(out_data_i.status), 64'(want.status));
        end
      end
    end
  end

endmodule

FILE: sim/rational_arith_reduce_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arith_reduce_core_tb
// Drives directed and random fraction beats with random gaps and stalls and
// gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module rational_arith_reduce_core_tb;
  import rar_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  int        fail_count;
  int        pending;

  rational_arith_reduce_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  rational_arith_reduce_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gap length: mostly short, now and then long, sometimes none
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // pick an operand: extremes, small values or anything
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3, 4, 5: return 16'($urandom_range(0, 40) - 20);
      default: return 16'($urandom());
    endcase
  endfunction

  // one beat: hold it until accepted, then the gap
  task automatic send_beat(input logic [1:0] func, input logic [15:0] ln,
                           input logic [15:0] ld, input logic [15:0] rn,
                           input logic [15:0] rd);
    int gap;
    in_data  <= {func, ln, ld, rn, rd};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    int n;
    if (rst_n) begin
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    int unsigned func_r;
    in_valid     = 1'b0;
    in_data      = '0;
    rst_n        = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every operation, extremes and special cases
    send_beat(FUNC_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_beat(FUNC_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_beat(FUNC_ADD, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_beat(FUNC_ADD, 16'sh8000, 16'sh0001, 16'sh8000, 16'sh0001);
    send_beat(FUNC_ADD, 16'd1, 16'd2, -16'sd1, 16'd2);
    send_beat(FUNC_ADD, 16'd3, 16'd0, 16'd1, 16'd5);
    send_beat(FUNC_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_beat(FUNC_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
    send_beat(FUNC_DIV, 16'd3, 16'd0, 16'd0, 16'd0);
    send_beat(FUNC_DIV, 16'sh8000, 16'd1, 16'd1, 16'sh8000);
    send_beat(FUNC_DIV, 16'd6, 16'd0, 16'd2, 16'd3);
    send_beat(FUNC_DIV, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_beat(FUNC_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_beat(FUNC_MUL, 16'sh7fff, 16'sh0001, 16'sh7fff, 16'sh0001);
    send_beat(FUNC_MUL, 16'd0, -16'sd7, 16'd5, 16'd3);
    send_beat(FUNC_MUL, 16'd4, 16'd6, 16'd9, 16'd0);
    send_beat(FUNC_MUL, -16'sd4, 16'd6, 16'd9, -16'sd2);
    send_beat(FUNC_BAD_OP, 16'd1, 16'd1, 16'd1, 16'd1);
    send_beat(FUNC_BAD_OP, 16'hffff, 16'd0, 16'hffff, 16'd0);
    send_beat(FUNC_ADD, 16'd0, -16'sd5, 16'd0, 16'd3);

    // random beats, unsupported code now and then
    repeat (450) begin
      func_r = $urandom_range(0, 19);
      send_beat((func_r < 6) ? FUNC_ADD : (func_r < 12) ? FUNC_DIV :
                (func_r < 18) ? FUNC_MUL : FUNC_BAD_OP,
                pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // run limit
  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
